/* sv/rau_pkg.sv */
`timescale 1ns / 1ps
// shared types, codes and widths for the rational arithmetic unit
package rau_pkg;
    localparam int VALUE_WIDTH = 32;
    localparam int MAG_W = 64;
    localparam int MAG_CW = 7;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_CMP = 3'd4
    } op_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIVZERO  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // classified job handed from front to back
    typedef struct packed {
        logic              direct;
        logic signed [31:0] res_num;
        logic [30:0]       res_den;
        logic              lt;
        logic              gt;
        logic              eq;
        logic [1:0]        st;
        logic              neg;
        logic [MAG_W-1:0]  mag;
        logic [MAG_W-1:0]  den;
    } job_t;

    localparam logic [MAG_W-1:0] POS_MAX = MAG_W'((64'd1 << (VALUE_WIDTH - 1)) - 64'd1);
    localparam logic [MAG_W-1:0] NEG_MAX = MAG_W'(64'd1 << (VALUE_WIDTH - 1));
endpackage

/* sv/rational_arithmetic_unit.sv */
`timescale 1ns / 1ps
// Rational arithmetic unit: add, subtract, multiply, divide or compare two fractions,
// with the result reduced by its gcd and the sign on the numerator. The front end takes
// one transaction at a time (operand capture, three signed 33x33 products, then
// classification), and a two-entry queue feeds the back end. The back end runs a
// one-step-per-cycle binary gcd loop over 64-bit magnitudes, then bit-serial
// division of numerator and denominator, a check state and the output register;
// compare, error, zero and unused-code results bypass that and go to the output register.
// Sustained throughput is set by the gcd and divide loops.
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         func,
    input  logic signed [31:0] a_num,
    input  logic [30:0]        a_den,
    input  logic signed [31:0] b_num,
    input  logic [30:0]        b_den,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] res_num,
    output logic [30:0]        res_den,
    output logic               is_less,
    output logic               is_greater,
    output logic               is_equal,
    output logic [1:0]         status
);
    logic f_valid, f_ready, q_valid, q_ready;
    job_t f_job, q_job;

    // front end
    rau_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
        .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
    );

    // queue
    rau_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
    );

    // back end
    rau_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
        .out_valid(out_valid), .out_ready(out_ready),
        .res_num(res_num), .res_den(res_den),
        .is_less(is_less), .is_greater(is_greater), .is_equal(is_equal),
        .status(status)
    );
endmodule

/* sv/rau_front.sv */
`timescale 1ns / 1ps
// front end: cross products, sign fixing and classification
module rau_front
    import rau_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         func,
    input  logic signed [31:0] a_num,
    input  logic [30:0]        a_den,
    input  logic signed [31:0] b_num,
    input  logic [30:0]        b_den,
    output logic               job_valid,
    input  logic               job_ready,
    output job_t               job
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL1 = 4'b0010,
        S_MUL2 = 4'b0100,
        S_OUT  = 4'b1000
    } fstate_t;

    fstate_t state_reg, state_next;
    logic [2:0] op_reg;
    logic signed [31:0] an_reg, bn_reg;
    logic [30:0] ad_reg, bd_reg;
    logic signed [63:0] p1_reg, p2_reg, p3_reg;
    job_t job_reg;

    // operands of the three signed 33x33 products
    logic signed [32:0] m1a, m1b, m2a, m2b, m3a, m3b;
    always_comb
    begin
        m1a = 33'(an_reg);
        m1b = {2'b00, bd_reg};
        m2a = 33'(bn_reg);
        m2b = {2'b00, ad_reg};
        m3a = {2'b00, ad_reg};
        m3b = (op_reg == OP_DIV) ? 33'(bn_reg) : {2'b00, bd_reg};
        if (op_reg == OP_MUL)
        begin
            m2a = 33'(an_reg);
            m2b = 33'(bn_reg);
        end
    end

    // classification of finished products
    job_t jn;
    logic signed [64:0] nsum, nfix;
    logic signed [64:0] dfix;
    always_comb
    begin
        jn = '0;
        jn.res_den = 31'd1;
        jn.st = ST_OK;
        nsum = '0;
        nfix = '0;
        dfix = '0;
        if (op_reg > OP_CMP)
        begin
            jn.direct = 1'b1;
        end
        else if (ad_reg == '0 || bd_reg == '0 || (op_reg == OP_DIV && bn_reg == '0))
        begin
            jn.direct = 1'b1;
            jn.res_den = '0;
            jn.st = ST_DIVZERO;
        end
        else if (op_reg == OP_CMP)
        begin
            jn.direct = 1'b1;
            jn.lt = p1_reg < p2_reg;
            jn.gt = p1_reg > p2_reg;
            jn.eq = p1_reg == p2_reg;
        end
        else
        begin
            case (op_reg)
                OP_ADD: nsum = 65'(p1_reg) + 65'(p2_reg);
                OP_SUB: nsum = 65'(p1_reg) - 65'(p2_reg);
                OP_MUL: nsum = 65'(p2_reg);
                default: nsum = 65'(p1_reg);
            endcase
            nfix = (p3_reg < 0) ? -nsum : nsum;
            dfix = (p3_reg < 0) ? -65'(p3_reg) : 65'(p3_reg);
            jn.neg = nfix < 0;
            jn.mag = jn.neg ? 64'(-nfix) : 64'(nfix);
            jn.den = 64'(dfix);
            jn.direct = (jn.mag == '0);
            if (jn.mag == '0)
                jn.neg = 1'b0;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign job_valid = (state_reg == S_OUT);
    assign job = job_reg;

    // control
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_valid) state_next = S_MUL1;
            S_MUL1: state_next = S_MUL2;
            S_MUL2: state_next = S_OUT;
            S_OUT:  if (job_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            op_reg <= func;
            an_reg <= a_num;
            ad_reg <= a_den;
            bn_reg <= b_num;
            bd_reg <= b_den;
        end
        if (state_reg == S_MUL1)
        begin
            p1_reg <= 64'(m1a * m1b);
            p2_reg <= 64'(m2a * m2b);
            p3_reg <= 64'(m3a * m3b);
        end
        if (state_reg == S_MUL2)
            job_reg <= jn;
    end
endmodule

/* sv/rau_queue.sv */
`timescale 1ns / 1ps
// two-entry queue between front and back
module rau_queue
    import rau_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  job_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output job_t rd_data
);
    job_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic wr_en, rd_en;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data = mem_reg[rp_reg];
    assign wr_en = wr_valid && wr_ready;
    assign rd_en = rd_valid && rd_ready;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en) wp_reg <= ~wp_reg;
            if (rd_en) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr_en) - 2'(rd_en);
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end
endmodule

/* sv/rau_back.sv */
`timescale 1ns / 1ps
// back end: binary gcd, two restoring divides, range check, output register
module rau_back
    import rau_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    output logic               job_ready,
    input  job_t               job,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] res_num,
    output logic [30:0]        res_den,
    output logic               is_less,
    output logic               is_greater,
    output logic               is_equal,
    output logic [1:0]         status
);
    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_GCD  = 5'b00010,
        B_DIV  = 5'b00100,
        B_CHK  = 5'b01000,
        B_OUT  = 5'b10000
    } bstate_t;

    bstate_t state_reg, state_next;
    job_t j_reg;
    logic [MAG_W-1:0] u_reg, v_reg;
    logic [MAG_CW-1:0] sh_reg, cnt_reg;
    logic [MAG_W-1:0] g_reg;
    logic [MAG_W-1:0] qm_reg, qd_reg, rm_reg, rd_reg;
    logic signed [31:0] on_reg;
    logic [30:0] od_reg;
    logic ol_reg, og_reg, oe_reg;
    logic [1:0] ost_reg;

    // one binary gcd step (stein)
    logic [MAG_W-1:0] u_n, v_n, dif;
    logic [MAG_CW-1:0] sh_n;
    logic gcd_done;
    always_comb
    begin
        u_n = u_reg;
        v_n = v_reg;
        sh_n = sh_reg;
        dif = '0;
        gcd_done = (v_reg == '0);
        if (!gcd_done)
        begin
            if (!u_reg[0] && !v_reg[0])
            begin
                u_n = u_reg >> 1;
                v_n = v_reg >> 1;
                sh_n = sh_reg + 1'b1;
            end
            else if (!u_reg[0])
                u_n = u_reg >> 1;
            else if (!v_reg[0])
                v_n = v_reg >> 1;
            else if (u_reg >= v_reg)
            begin
                dif = u_reg - v_reg;
                u_n = v_reg;
                v_n = dif;
            end
            else
                v_n = v_reg - u_reg;
        end
    end

    // one restoring division step for each of mag/g and den/g
    logic [MAG_W:0] tm, td;
    logic [MAG_W-1:0] rm_n, rd_n;
    logic qbm, qbd;
    always_comb
    begin
        tm = {rm_reg, qm_reg[MAG_W-1]};
        td = {rd_reg, qd_reg[MAG_W-1]};
        qbm = tm >= {1'b0, g_reg};
        qbd = td >= {1'b0, g_reg};
        rm_n = qbm ? MAG_W'(tm - {1'b0, g_reg}) : tm[MAG_W-1:0];
        rd_n = qbd ? MAG_W'(td - {1'b0, g_reg}) : td[MAG_W-1:0];
    end

    // range check
    logic ovf;
    always_comb
    begin
        ovf = (qd_reg > POS_MAX) || (j_reg.neg ? (qm_reg > NEG_MAX) : (qm_reg > POS_MAX));
    end

    assign job_ready = (state_reg == B_IDLE);
    assign out_valid = (state_reg == B_OUT);
    assign res_num = on_reg;
    assign res_den = od_reg;
    assign is_less = ol_reg;
    assign is_greater = og_reg;
    assign is_equal = oe_reg;
    assign status = ost_reg;

    // control
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: if (job_valid) state_next = job.direct ? B_OUT : B_GCD;
            B_GCD:  if (gcd_done) state_next = B_DIV;
            B_DIV:  if (cnt_reg == MAG_CW'(MAG_W - 1)) state_next = B_CHK;
            B_CHK:  state_next = B_OUT;
            B_OUT:  if (out_ready) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= B_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                j_reg <= job;
                u_reg <= job.mag;
                v_reg <= job.den;
                sh_reg <= '0;
                on_reg <= job.res_num;
                od_reg <= job.res_den;
                ol_reg <= job.lt;
                og_reg <= job.gt;
                oe_reg <= job.eq;
                ost_reg <= job.st;
            end
            B_GCD:
            begin
                u_reg <= u_n;
                v_reg <= v_n;
                sh_reg <= sh_n;
                if (gcd_done)
                begin
                    g_reg <= u_reg << sh_reg;
                    qm_reg <= j_reg.mag;
                    qd_reg <= j_reg.den;
                    rm_reg <= '0;
                    rd_reg <= '0;
                    cnt_reg <= '0;
                end
            end
            B_DIV:
            begin
                rm_reg <= rm_n;
                rd_reg <= rd_n;
                qm_reg <= {qm_reg[MAG_W-2:0], qbm};
                qd_reg <= {qd_reg[MAG_W-2:0], qbd};
                cnt_reg <= cnt_reg + 1'b1;
            end
            B_CHK:
            begin
                ol_reg <= 1'b0;
                og_reg <= 1'b0;
                oe_reg <= 1'b0;
                if (ovf)
                begin
                    on_reg <= '0;
                    od_reg <= '0;
                    ost_reg <= ST_OVERFLOW;
                end
                else
                begin
                    on_reg <= j_reg.neg ? -qm_reg[31:0] : qm_reg[31:0];
                    od_reg <= qd_reg[30:0];
                    ost_reg <= ST_OK;
                end
            end
            default:
            begin
            end
        endcase
    end
endmodule

/* tb/tb_rational_arithmetic_unit.sv */
`timescale 1ns / 1ps
// testbench for the rational arithmetic unit: directed and random fractions against a predictor
module tb_rational_arithmetic_unit;
    import rau_pkg::*;

    typedef struct {
        logic signed [31:0] num;
        logic [30:0]        den;
        logic               lt;
        logic               gt;
        logic               eq;
        logic [1:0]         st;
    } rat_res_t;

    int unsigned err_count = 0;

    // one mismatch, one line
    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    class rat_scoreboard;
        rat_res_t pending[$];

        function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
            longint unsigned r;
            while (y != 0)
            begin
                r = x % y;
                x = y;
                y = r;
            end
            return x;
        endfunction

        // exact fraction arithmetic for one operation
        function automatic rat_res_t reduce_fraction(logic [2:0] f, logic signed [31:0] an,
                                                     logic [30:0] ad, logic signed [31:0] bn,
                                                     logic [30:0] bd);
            rat_res_t r;
            longint n, d, l, rr;
            longint unsigned mag, dm, g;
            bit neg;
            r = '{num: 0, den: 1, lt: 0, gt: 0, eq: 0, st: ST_OK};
            if (f > OP_CMP)
                return r;
            if (ad == 0 || bd == 0 || (f == OP_DIV && bn == 0))
            begin
                r.den = 0;
                r.st = ST_DIVZERO;
                return r;
            end
            case (f)
                OP_ADD: begin n = longint'(an) * bd + longint'(bn) * ad; d = longint'(ad) * bd; end
                OP_SUB: begin n = longint'(an) * bd - longint'(bn) * ad; d = longint'(ad) * bd; end
                OP_MUL: begin n = longint'(an) * bn; d = longint'(ad) * bd; end
                OP_DIV: begin n = longint'(an) * bd; d = longint'(ad) * bn; end
                default:
                begin
                    l = longint'(an) * bd;
                    rr = longint'(bn) * ad;
                    r.lt = l < rr;
                    r.gt = l > rr;
                    r.eq = l == rr;
                    return r;
                end
            endcase
            if (d < 0)
            begin
                d = -d;
                n = -n;
            end
            neg = n < 0;
            mag = neg ? longint'(-n) : n;
            dm = d;
            if (mag == 0)
                return r;
            g = gcd64(mag, dm);
            mag /= g;
            dm /= g;
            if (dm > POS_MAX || (neg ? mag > NEG_MAX : mag > POS_MAX))
            begin
                r.den = 0;
                r.st = ST_OVERFLOW;
                return r;
            end
            r.num = neg ? -longint'(mag) : longint'(mag);
            r.den = dm[30:0];
            return r;
        endfunction

        function automatic void note_input(logic [2:0] f, logic signed [31:0] an, logic [30:0] ad,
                                           logic signed [31:0] bn, logic [30:0] bd);
            pending.push_back(reduce_fraction(f, an, ad, bn, bd));
        endfunction

        task automatic check_result(rat_res_t got);
            rat_res_t w;
            if (pending.size() == 0)
            begin
                report("unexpected result", got.num, 0);
                return;
            end
            w = pending.pop_front();
            if (got.num !== w.num) report("res_num", got.num, w.num);
            if (got.den !== w.den) report("res_den", got.den, w.den);
            if (got.lt !== w.lt) report("is_less", got.lt, w.lt);
            if (got.gt !== w.gt) report("is_greater", got.gt, w.gt);
            if (got.eq !== w.eq) report("is_equal", got.eq, w.eq);
            if (got.st !== w.st) report("status", got.st, w.st);
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0, out_ready = 0;
    logic in_ready, out_valid;
    logic [2:0] func = 0;
    logic signed [31:0] a_num = 0, b_num = 0;
    logic [30:0] a_den = 1, b_den = 1;
    logic signed [31:0] res_num;
    logic [30:0] res_den;
    logic is_less, is_greater, is_equal;
    logic [1:0] status;
    rat_scoreboard sb = new();
    longint unsigned cycles = 0;

    rational_arithmetic_unit u_dut (.*);

    always #4 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2000000)
        begin
            $display("FAIL rational_arithmetic_unit");
            $finish;
        end
    end

    // result side: random stall per transaction, sample at rising edge
    initial
    begin
        rat_res_t got;
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                out_ready <= 0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1;
            do @(posedge clk); while (!out_valid);
            got = '{num: res_num, den: res_den, lt: is_less, gt: is_greater, eq: is_equal,
                    st: status};
            sb.check_result(got);
            @(negedge clk);
        end
    end

    task automatic send(logic [2:0] f, logic signed [31:0] an, logic [30:0] ad,
                        logic signed [31:0] bn, logic [30:0] bd, int gap);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        func <= f; a_num <= an; a_den <= ad; b_num <= bn; b_den <= bd;
        in_valid <= 1;
        do @(posedge clk); while (!in_ready);
        sb.note_input(f, an, ad, bn, bd);
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_val();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 40) - 20;
            2: return $urandom_range(0, 65535);
            3: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom)} >> $urandom_range(0, 31);
            default: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
        endcase
    endfunction

    function automatic logic [30:0] rand_den();
        logic [30:0] d;
        case ($urandom_range(0, 3))
            0: d = 31'($urandom);
            1: d = 31'($urandom_range(1, 12));
            2: d = 31'($urandom) >> $urandom_range(0, 30);
            default: d = 31'h7FFFFFFF;
        endcase
        return (d == 0) ? 31'd1 : d;
    endfunction

    initial
    begin
        logic [2:0] f;
        logic [30:0] ad, bd;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        // directed corners
        send(OP_ADD, 1, 2, 1, 3, 0);
        send(OP_SUB, 1, 2, 1, 2, 0);
        send(OP_MUL, -3, 4, 4, 3, 1);
        send(OP_DIV, 5, 7, 0, 1, 0);
        send(OP_DIV, 5, 7, -10, 14, 0);
        send(OP_CMP, 1, 3, 2, 6, 0);
        send(OP_CMP, -1, 3, 1, 3, 0);
        send(OP_CMP, 32'h7FFFFFFF, 1, 32'h80000000, 1, 0);
        send(OP_ADD, 32'h7FFFFFFF, 1, 32'h7FFFFFFF, 1, 0);
        send(OP_MUL, 32'h80000000, 1, 32'h80000000, 1, 0);
        send(OP_MUL, 32'h80000000, 1, 1, 1, 0);
        send(OP_DIV, 32'h80000000, 1, -1, 1, 0);
        send(OP_SUB, 32'h80000000, 31'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF, 0);
        send(OP_ADD, 1, 31'h7FFFFFFF, 1, 31'h7FFFFFFE, 0);
        send(OP_ADD, 5, 0, 1, 1, 0);
        send(OP_CMP, 5, 1, 1, 0, 0);
        send(OP_MUL, 0, 5, -7, 3, 0);
        send(3'd5, 1, 1, 1, 1, 0);
        send(3'd6, -1, 0, 1, 0, 0);
        send(3'd7, 32'hFFFFFFFF, 31'h7FFFFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF, 0);
        in_valid <= 0;
        // let everything drain before random traffic
        wait (sb.pending.size() == 0);
        repeat (300) @(negedge clk);
        for (int i = 0; i < 800; i++)
        begin
            f = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
            ad = ($urandom_range(0, 49) == 0) ? 31'd0 : rand_den();
            bd = ($urandom_range(0, 49) == 0) ? 31'd0 : rand_den();
            send(f, rand_val(), ad, ($urandom_range(0, 15) == 0) ? 32'd0 : rand_val(), bd,
                 ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6));
        end
        in_valid <= 0;
        wait (sb.pending.size() == 0);
        repeat (300) @(negedge clk);
        if (err_count == 0)
            $display("PASS rational_arithmetic_unit");
        else
            $display("FAIL rational_arithmetic_unit");
        $finish;
    end
endmodule
